// ===== rtl/qtl_pkg.sv =====
// qtl_pkg: shared types and constants for the query token lexer.
// No dependencies; imported by qtl_scan and query_token_lexer.
package qtl_pkg;

   localparam int POS_W  = 16;   // offset counter and token offset/length width
   localparam int TYPE_W = 5;    // token type code width

   localparam logic [POS_W-1:0] POS_MAX = '1;

   // Scanner mode, one-hot.
   typedef enum logic [6:0] {
      MODE_IDLE     = 7'b0000001,
      MODE_IDENT    = 7'b0000010,
      MODE_FIRSTDIG = 7'b0000100,
      MODE_NUMBER   = 7'b0001000,
      MODE_HEX      = 7'b0010000,
      MODE_STRING   = 7'b0100000,
      MODE_SYMBOL   = 7'b1000000
   } mode_type;

   typedef enum logic [TYPE_W-1:0] {
      TOK_EOF     = 5'd0,
      TOK_IDENT   = 5'd1,
      TOK_NUMBER  = 5'd2,
      TOK_HEX     = 5'd3,
      TOK_STRING  = 5'd4,
      TOK_LT      = 5'd5,
      TOK_GT      = 5'd6,
      TOK_LE      = 5'd7,
      TOK_GE      = 5'd8,
      TOK_NE      = 5'd9,
      TOK_EQ      = 5'd10,
      TOK_LPAR    = 5'd11,
      TOK_RPAR    = 5'd12,
      TOK_COMMA   = 5'd13,
      TOK_STAR    = 5'd14,
      TOK_SEMI    = 5'd15,
      TOK_INVALID = 5'd16
   } token_kind_type;

   typedef struct packed {
      token_kind_type   tok_kind;
      logic [POS_W-1:0] token_start;
      logic [POS_W-1:0] token_length;
      logic             overflow;
      logic             last;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type res;
   } slot_type;

endpackage

// ===== rtl/qtl_scan.sv =====
// qtl_scan: lexer state and per-item token logic; gives up to two result slots.
// Depends on qtl_pkg.
module qtl_scan
   import qtl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  logic       in_end,
   input  logic [7:0] in_char,
   output slot_type   res0,
   output slot_type   res1
);

   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_decimal(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_hexdig(input logic [7:0] c);
      return is_decimal(c) || (c >= 8'h61 && c <= 8'h66);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_CR;
   endfunction

   function automatic token_kind_type single_kind(input logic [7:0] c);
      token_kind_type k;
      unique case (c)
         CH_LT:    k = TOK_LT;
         CH_GT:    k = TOK_GT;
         CH_EQ:    k = TOK_EQ;
         CH_LPAR:  k = TOK_LPAR;
         CH_RPAR:  k = TOK_RPAR;
         CH_COMMA: k = TOK_COMMA;
         CH_STAR:  k = TOK_STAR;
         CH_SEMI:  k = TOK_SEMI;
         default:  k = TOK_INVALID;
      endcase
      return k;
   endfunction

   // Length from b up to e, zero when e is below b.
   function automatic logic [POS_W-1:0] span(input logic [POS_W-1:0] e,
                                             input logic [POS_W-1:0] b);
      return (e >= b) ? (e - b) : '0;
   endfunction

   function automatic logic [POS_W-1:0] sat_next(input logic [POS_W-1:0] v);
      return (v == POS_MAX) ? POS_MAX : (v + POS_W'(1));
   endfunction

   mode_type         mode_ff, mode_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] tb_ff, tb_in;
   logic             dot_ff, dot_in;
   logic [7:0]       held_ff, held_in;
   logic             ovf_ff, ovf_in;

   // pending-token flush and idle-start decode
   token_kind_type   flush_kind;
   logic [POS_W-1:0] flush_len;
   mode_type         beg_mode;
   logic             beg_emit;
   logic             ovf_now;
   logic             brk;
   logic             start;

   always_comb begin
      unique case (mode_ff)
         MODE_IDENT:    flush_kind = TOK_IDENT;
         MODE_FIRSTDIG: flush_kind = TOK_NUMBER;
         MODE_NUMBER:   flush_kind = TOK_NUMBER;
         MODE_HEX:      flush_kind = dot_ff ? TOK_HEX : TOK_INVALID;
         MODE_STRING:   flush_kind = TOK_INVALID;
         MODE_SYMBOL:   flush_kind = single_kind(held_ff);
         default:       flush_kind = TOK_EOF;
      endcase
      flush_len = (mode_ff == MODE_SYMBOL) ? POS_W'(1) : span(pos_ff, tb_ff);

      priority if (is_space(in_char)) begin
         beg_mode = MODE_IDLE;
         beg_emit = 1'b0;
      end else if (is_letter(in_char)) begin
         beg_mode = MODE_IDENT;
         beg_emit = 1'b0;
      end else if (is_decimal(in_char)) begin
         beg_mode = MODE_FIRSTDIG;
         beg_emit = 1'b0;
      end else if (in_char == CH_QUOTE) begin
         beg_mode = MODE_STRING;
         beg_emit = 1'b0;
      end else if (in_char == CH_LT || in_char == CH_GT || in_char == CH_BANG) begin
         beg_mode = MODE_SYMBOL;
         beg_emit = 1'b0;
      end else begin
         beg_mode = MODE_IDLE;
         beg_emit = 1'b1;
      end
   end

   always_comb begin
      mode_in = mode_ff;
      pos_in  = pos_ff;
      tb_in   = tb_ff;
      dot_in  = dot_ff;
      held_in = held_ff;
      ovf_in  = ovf_ff;
      res0    = '0;
      res1    = '0;
      brk     = 1'b0;
      start   = 1'b0;
      ovf_now = ovf_ff | (pos_ff == POS_MAX);

      if (in_valid && in_end) begin
         // flush, then eof; state back to reset
         res0.valid            = (mode_ff != MODE_IDLE);
         res0.res.tok_kind     = flush_kind;
         res0.res.token_start  = tb_ff;
         res0.res.token_length = flush_len;
         res0.res.overflow     = ovf_ff;
         res1.valid            = 1'b1;
         res1.res.tok_kind     = TOK_EOF;
         res1.res.token_start  = pos_ff;
         res1.res.token_length = '0;
         res1.res.overflow     = ovf_ff;
         res1.res.last         = 1'b1;
         mode_in = MODE_IDLE;
         pos_in  = '0;
         tb_in   = '0;
         dot_in  = 1'b0;
         held_in = '0;
         ovf_in  = 1'b0;
      end else if (in_valid) begin
         pos_in = sat_next(pos_ff);
         ovf_in = ovf_now;
         unique case (mode_ff)
            MODE_IDENT: begin
               brk = !(is_letter(in_char) || is_decimal(in_char) || in_char == CH_UNDER);
            end
            MODE_FIRSTDIG: begin
               priority if (in_char == CH_X) begin
                  mode_in = MODE_HEX;
                  tb_in   = sat_next(pos_ff);
                  dot_in  = 1'b0;
               end else if (is_decimal(in_char)) begin
                  mode_in = MODE_NUMBER;
               end else if (in_char == CH_DOT) begin
                  mode_in = MODE_NUMBER;
                  dot_in  = 1'b1;
               end else begin
                  brk = 1'b1;
               end
            end
            MODE_NUMBER: begin
               priority if (is_decimal(in_char)) begin
                  dot_in = dot_ff;
               end else if (in_char == CH_DOT && !dot_ff) begin
                  dot_in = 1'b1;
               end else begin
                  brk = 1'b1;
               end
            end
            MODE_HEX: begin
               if (is_hexdig(in_char)) begin
                  dot_in = 1'b1;          // at least one hex digit seen
               end else begin
                  brk = 1'b1;
               end
            end
            MODE_STRING: begin
               if (in_char == CH_QUOTE) begin
                  res0.valid            = 1'b1;
                  res0.res.tok_kind     = TOK_STRING;
                  res0.res.token_start  = tb_ff;
                  res0.res.token_length = span(pos_ff, tb_ff);
                  mode_in               = MODE_IDLE;
               end
            end
            MODE_SYMBOL: begin
               if (in_char == CH_EQ) begin
                  res0.valid            = 1'b1;
                  res0.res.tok_kind     = (held_ff == CH_LT) ? TOK_LE :
                                          (held_ff == CH_GT) ? TOK_GE : TOK_NE;
                  res0.res.token_start  = tb_ff;
                  res0.res.token_length = POS_W'(2);
                  mode_in               = MODE_IDLE;
               end else begin
                  brk = 1'b1;
               end
            end
            default: begin
               start = 1'b1;
            end
         endcase

         if (brk) begin
            res0.valid            = 1'b1;
            res0.res.tok_kind     = flush_kind;
            res0.res.token_start  = tb_ff;
            res0.res.token_length = flush_len;
            dot_in                = 1'b0;
         end

         if (brk || start) begin
            mode_in = beg_mode;
            unique case (beg_mode)
               MODE_IDENT:    tb_in = pos_ff;
               MODE_FIRSTDIG: begin
                  tb_in  = pos_ff;
                  dot_in = 1'b0;
               end
               MODE_STRING:   tb_in = sat_next(pos_ff);
               MODE_SYMBOL:   begin
                  tb_in   = pos_ff;
                  held_in = in_char;
               end
               default:       tb_in = tb_ff;
            endcase
            res1.valid            = beg_emit;
            res1.res.tok_kind     = single_kind(in_char);
            res1.res.token_start  = pos_ff;
            res1.res.token_length = POS_W'(1);
         end

         res0.res.overflow = ovf_now;
         res1.res.overflow = ovf_now;
         res1.res.last     = res1.valid;
         res0.res.last     = res0.valid && !res1.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         pos_ff  <= '0;
         tb_ff   <= '0;
         dot_ff  <= 1'b0;
         held_ff <= '0;
         ovf_ff  <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
         tb_ff   <= tb_in;
         dot_ff  <= dot_in;
         held_ff <= held_in;
         ovf_ff  <= ovf_in;
      end
   end

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_end |=> mode_ff == MODE_IDLE && pos_ff == '0 && !ovf_ff)
      else $error("end item did not return scanner to reset state");

   a_ovf_saturated: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> pos_ff == POS_MAX)
      else $error("overflow flag set with unsaturated position");

   a_second_slot_last: assert property (@(posedge clock) disable iff (reset)
      res1.valid |-> res1.res.last && !res0.res.last)
      else $error("last marker not on final result of item");

endmodule

// ===== rtl/query_token_lexer.sv =====
// query_token_lexer: streaming tokenizer top level, input stage and result queue.
// Depends on qtl_pkg and qtl_scan.
//
// Usage:
//   req channel: one item per handshake. req_tdata is the byte, req_tuser is
//   the kind (0 data byte, 1 end of input). An end item flushes any pending
//   token, emits an EOF token and restarts offsets at 0 for the next stream.
//   rsp channel: one token per handshake; rsp_tuser carries the token type,
//   rsp_tdata the offset, length and overflow flag, rsp_tlast marks the last
//   token caused by one input item. An item yields zero, one or two tokens.
// Path: an accepted item is registered in the input stage, scanned there by
//   qtl_scan and its tokens are written to the queue before they reach rsp.
// Throughput: one item per cycle while req_tready is high. Tokens leave one per
//   cycle via an 8-entry queue; req_tready drops while it holds over 4 tokens,
//   which leaves room for the item in the stage plus the next one (two each).
// Stall: when rsp_tready is low, tokens wait in the queue and input keeps
//   flowing until the queue limit is reached; nothing is dropped.
// Reset: synchronous, active high; clears the queue, the stage and the scanner
//   state (idle, offset 0, overflow clear).
module query_token_lexer
   import qtl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_req
   input  logic        req_tuser,   // [0] kind
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [15:0] token_start, [31:16] token_length,
                                    // [32] overflow, [39:33] zero
   output logic [4:0]  rsp_tuser,   // [4:0] token kind
   output logic        rsp_tlast    // last
);

   localparam int Q_DEPTH     = 8;
   localparam int Q_PTR_W     = 3;
   localparam int Q_CNT_W     = 4;
   localparam int Q_READY_MAX = 4;

   // input stage
   logic       stg_valid_ff;
   logic       stg_end_ff;
   logic [7:0] stg_char_ff;
   logic       req_fire;

   slot_type   res0;
   slot_type   res1;

   // result queue
   result_type           q_mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   q_wr_ff, q_wr_in;
   logic [Q_PTR_W-1:0]   q_rd_ff, q_rd_in;
   logic [Q_CNT_W-1:0]   q_cnt_ff, q_cnt_in;
   logic [1:0]           n_push;
   logic                 pop;
   result_type           push_first;
   result_type           head;

   assign req_tready = (q_cnt_ff <= Q_CNT_W'(Q_READY_MAX));
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stg_end_ff  <= req_tuser;
         stg_char_ff <= req_tdata;
      end
   end

   qtl_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .in_valid (stg_valid_ff),
      .in_end   (stg_end_ff),
      .in_char  (stg_char_ff),
      .res0     (res0),
      .res1     (res1)
   );

   // compact the two slots into consecutive queue entries
   always_comb begin
      n_push     = {1'b0, res0.valid} + {1'b0, res1.valid};
      push_first = res0.valid ? res0.res : res1.res;
      pop        = rsp_tvalid && rsp_tready;
      q_wr_in    = q_wr_ff + Q_PTR_W'(n_push);
      q_rd_in    = q_rd_ff + Q_PTR_W'(pop);
      q_cnt_in   = q_cnt_ff + Q_CNT_W'(n_push) - Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff  <= '0;
         q_rd_ff  <= '0;
         q_cnt_ff <= '0;
      end else begin
         q_wr_ff  <= q_wr_in;
         q_rd_ff  <= q_rd_in;
         q_cnt_ff <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         q_mem_ff[q_wr_ff] <= push_first;
      end
      if (n_push == 2'd2) begin
         q_mem_ff[q_wr_ff + Q_PTR_W'(1)] <= res1.res;
      end
   end

   assign head       = q_mem_ff[q_rd_ff];
   assign rsp_tvalid = (q_cnt_ff != '0);
   assign rsp_tuser  = head.tok_kind;
   assign rsp_tlast  = head.last;
   assign rsp_tdata  = {7'b0, head.overflow, head.token_length, head.token_start};

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("result queue overrun");

   a_eof_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == TOK_EOF |-> rsp_tlast)
      else $error("EOF token without last marker");

endmodule
